>>> design/assert_macros.svh
// Assertion macros for the smallest-period hash design.
// Depends on nothing; included by smallest_period_rolling_hash, the module that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SPR_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SPR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/spr_pkg.sv
// Shared types and constants for the smallest-period double hash block.
// No dependencies; used by every module of the block.
package spr_pkg;

   localparam int HASH_W          = 30;
   localparam int LANES           = 2;
   localparam int BASE_W          = 8;
   localparam int LETTER_W        = 7;
   localparam int PERIOD_W        = 11;
   localparam int MAX_LEN_DEFAULT = 1024;

   typedef logic [HASH_W-1:0] hash_type;

   // lane 0: base 31 modulo 1e9+7, lane 1: base 131 modulo 1e9+9
   localparam hash_type MODULUS [LANES] = '{30'd1000000007, 30'd1000000009};
   localparam logic [BASE_W-1:0] BASE [LANES] = '{8'd31, 8'd131};

   // letter value is the code minus this, wrapped to the letter width
   localparam logic [LETTER_W-1:0] LETTER_OFFSET = 7'd96;

   typedef enum logic [1:0] {
      LN_HOLD,
      LN_LOAD,
      LN_MUL,
      LN_ADD
   } lane_op_type;

   typedef struct packed {
      lane_op_type op;
      hash_type    load_x;
      hash_type    load_m;
      hash_type    addend;
   } lane_ctl_type;

endpackage

>>> design/smallest_period_rolling_hash.sv
// Each letter beat holds busy while the lanes update the power and hash (only the overflow is
// marked once the string has overflowed); the serial lanes take one multiplier bit per cycle,
// over the 8-bit base for power and again for hash. After the last letter the divisor search
// tries multiples of each length, then checks blocks by a 30-bit multiply by the stored power.
// The receiver cannot stall: rsp_strobe is high for one cycle per string, after the emit step.
// Synchronous reset clears the sequencer, length and running hashes; the memories are not cleared.
`include "assert_macros.svh"
module smallest_period_rolling_hash #(
   parameter int MAX_LEN = spr_pkg::MAX_LEN_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [spr_pkg::LETTER_W-1:0]  req_letter,
   input  logic                          req_last,
   output logic                          rsp_strobe,
   output logic [spr_pkg::PERIOD_W-1:0]  rsp_period,
   output logic                          rsp_overflow
);
   import spr_pkg::*;

   localparam int ADDR_W = $clog2(MAX_LEN + 1);
   localparam int LEN_W  = $clog2(MAX_LEN + 2);
   localparam int CMP_W  = ADDR_W + 1;
   localparam int LOOP_W = $clog2(HASH_W);
   localparam int RAM_W  = HASH_W * LANES;
   localparam logic [CMP_W-1:0] MAX_LEN_C = CMP_W'(MAX_LEN);
   localparam logic [LEN_W-1:0] LEN_OVF   = LEN_W'(MAX_LEN + 1);

   // microcode step addresses
   typedef logic [4:0] upc_type;
   localparam upc_type US_IDLE = 5'd0;
   localparam upc_type US_LCHK = 5'd1;
   localparam upc_type US_MULP = 5'd2;
   localparam upc_type US_PSAV = 5'd3;
   localparam upc_type US_MULH = 5'd4;
   localparam upc_type US_ADDV = 5'd5;
   localparam upc_type US_HSAV = 5'd6;
   localparam upc_type US_OVFM = 5'd7;
   localparam upc_type US_LAST = 5'd8;
   localparam upc_type US_SINI = 5'd9;
   localparam upc_type US_DINI = 5'd10;
   localparam upc_type US_DLOP = 5'd11;
   localparam upc_type US_DCHK = 5'd12;
   localparam upc_type US_NXTD = 5'd13;
   localparam upc_type US_RDD  = 5'd14;
   localparam upc_type US_CAPD = 5'd15;
   localparam upc_type US_RDLO = 5'd16;
   localparam upc_type US_RDHI = 5'd17;
   localparam upc_type US_MULB = 5'd18;
   localparam upc_type US_ADDD = 5'd19;
   localparam upc_type US_CMP  = 5'd20;
   localparam upc_type US_BEND = 5'd21;
   localparam upc_type US_EMIT = 5'd22;

   typedef enum logic [2:0] {
      UL_HOLD, UL_LOAD_P, UL_LOAD_H, UL_LOAD_B, UL_MUL, UL_ADD_V, UL_ADD_HD
   } uc_lane_type;

   typedef enum logic [3:0] {
      UA_NONE, UA_SAVE_P, UA_SAVE_H, UA_MARK_OVF, UA_D_ONE, UA_SUM_D,
      UA_SUM_ADD, UA_D_INC, UA_LO_D, UA_CAP_D, UA_LO_ADD, UA_EMIT
   } uc_act_type;

   typedef enum logic [1:0] {
      UR_NONE, UR_D, UR_LO, UR_HI
   } uc_read_type;

   typedef enum logic [3:0] {
      UC_NEXT, UC_ALWAYS, UC_NOT_START, UC_LEN_FULL, UC_LOOP, UC_NOT_LAST,
      UC_OVF, UC_SUM_EQ, UC_SUM_LE, UC_LO_EQ, UC_LO_NE, UC_MISMATCH
   } uc_cond_type;

   typedef struct packed {
      uc_lane_type lane;
      uc_act_type  act;
      uc_read_type rd;
      uc_cond_type cond;
      upc_type     target;
   } uword_type;

   // control store: one word per step, jump to target when the condition holds
   function automatic uword_type ucode_rom(input upc_type pc);
      uword_type w;
      begin
         case (pc)
            US_IDLE: w = '{UL_HOLD,   UA_NONE,     UR_NONE, UC_NOT_START, US_IDLE};
            US_LCHK: w = '{UL_LOAD_P, UA_NONE,     UR_NONE, UC_LEN_FULL,  US_OVFM};
            US_MULP: w = '{UL_MUL,    UA_NONE,     UR_NONE, UC_LOOP,      US_MULP};
            US_PSAV: w = '{UL_LOAD_H, UA_SAVE_P,   UR_NONE, UC_NEXT,      US_IDLE};
            US_MULH: w = '{UL_MUL,    UA_NONE,     UR_NONE, UC_LOOP,      US_MULH};
            US_ADDV: w = '{UL_ADD_V,  UA_NONE,     UR_NONE, UC_NEXT,      US_IDLE};
            US_HSAV: w = '{UL_HOLD,   UA_SAVE_H,   UR_NONE, UC_ALWAYS,    US_LAST};
            US_OVFM: w = '{UL_HOLD,   UA_MARK_OVF, UR_NONE, UC_NEXT,      US_IDLE};
            US_LAST: w = '{UL_HOLD,   UA_NONE,     UR_NONE, UC_NOT_LAST,  US_IDLE};
            US_SINI: w = '{UL_HOLD,   UA_D_ONE,    UR_NONE, UC_OVF,       US_EMIT};
            US_DINI: w = '{UL_HOLD,   UA_SUM_D,    UR_NONE, UC_NEXT,      US_IDLE};
            US_DLOP: w = '{UL_HOLD,   UA_SUM_ADD,  UR_NONE, UC_SUM_EQ,    US_RDD};
            US_DCHK: w = '{UL_HOLD,   UA_NONE,     UR_NONE, UC_SUM_LE,    US_DLOP};
            US_NXTD: w = '{UL_HOLD,   UA_D_INC,    UR_NONE, UC_ALWAYS,    US_DINI};
            US_RDD:  w = '{UL_HOLD,   UA_LO_D,     UR_D,    UC_NEXT,      US_IDLE};
            US_CAPD: w = '{UL_HOLD,   UA_CAP_D,    UR_NONE, UC_LO_EQ,     US_EMIT};
            US_RDLO: w = '{UL_HOLD,   UA_NONE,     UR_LO,   UC_NEXT,      US_IDLE};
            US_RDHI: w = '{UL_LOAD_B, UA_NONE,     UR_HI,   UC_NEXT,      US_IDLE};
            US_MULB: w = '{UL_MUL,    UA_NONE,     UR_NONE, UC_LOOP,      US_MULB};
            US_ADDD: w = '{UL_ADD_HD, UA_NONE,     UR_NONE, UC_NEXT,      US_IDLE};
            US_CMP:  w = '{UL_HOLD,   UA_LO_ADD,   UR_NONE, UC_MISMATCH,  US_NXTD};
            US_BEND: w = '{UL_HOLD,   UA_NONE,     UR_NONE, UC_LO_NE,     US_RDLO};
            US_EMIT: w = '{UL_HOLD,   UA_EMIT,     UR_NONE, UC_ALWAYS,    US_IDLE};
            default: w = '{UL_HOLD,   UA_NONE,     UR_NONE, UC_ALWAYS,    US_IDLE};
         endcase
         return w;
      end
   endfunction

   // sequencer and control registers
   upc_type            upc_ff, upc_in;
   logic [LOOP_W-1:0]  loop_ff, loop_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   hash_type           run_h_ff [LANES];
   hash_type           run_h_in [LANES];
   hash_type           run_p_ff [LANES];
   hash_type           run_p_in [LANES];
   logic               rsp_strobe_ff, rsp_strobe_in;

   // datapath registers
   logic [LETTER_W-1:0] value_ff, value_in;
   logic                last_ff, last_in;
   logic [ADDR_W-1:0]   d_ff, d_in;
   logic [ADDR_W-1:0]   lo_ff, lo_in;
   logic [CMP_W-1:0]    sum_ff, sum_in;
   hash_type            hd_ff [LANES];
   hash_type            hd_in [LANES];
   hash_type            pwd_ff [LANES];
   hash_type            pwd_in [LANES];
   logic [PERIOD_W-1:0] rsp_period_ff, rsp_period_in;
   logic                rsp_overflow_ff, rsp_overflow_in;

   uword_type          uw;
   logic               accept;
   logic               jump;
   logic               mismatch;
   logic               len_over;
   logic [CMP_W-1:0]   len_ext;
   logic [CMP_W-1:0]   hi_ext;
   hash_type           acc [LANES];
   lane_ctl_type       lane_ctl [LANES];
   logic [RAM_W-1:0]   pre_wr_data, pw_wr_data;
   logic [RAM_W-1:0]   pre_rd_data, pw_rd_data;
   hash_type           pre_rd [LANES];
   hash_type           pw_rd [LANES];
   logic               ram_wr_en;
   logic [ADDR_W-1:0]  ram_wr_addr;
   logic               pre_rd_en, pw_rd_en;
   logic [ADDR_W-1:0]  ram_rd_addr;

   assign uw       = ucode_rom(upc_ff);
   assign busy     = (upc_ff != US_IDLE);
   assign accept   = start && !busy;
   assign len_ext  = CMP_W'(len_ff);
   assign len_over = (len_ext > MAX_LEN_C);
   assign hi_ext   = CMP_W'(lo_ff) + CMP_W'(d_ff);

   // lanes, their memory words and per-lane control
   for (genvar g = 0; g < LANES; g++) begin : g_lane
      assign pre_rd[g] = pre_rd_data[g*HASH_W +: HASH_W];
      assign pw_rd[g]  = pw_rd_data[g*HASH_W +: HASH_W];
      assign pre_wr_data[g*HASH_W +: HASH_W] = acc[g];
      assign pw_wr_data[g*HASH_W +: HASH_W]  = run_p_ff[g];

      always_comb begin
         lane_ctl[g].op     = LN_HOLD;
         lane_ctl[g].load_x = run_p_ff[g];
         lane_ctl[g].load_m = {BASE[g], {(HASH_W - BASE_W){1'b0}}};
         lane_ctl[g].addend = HASH_W'(value_ff);
         case (uw.lane)
            UL_HOLD: begin
            end
            UL_LOAD_P: begin
               lane_ctl[g].op = LN_LOAD;
            end
            UL_LOAD_H: begin
               lane_ctl[g].op     = LN_LOAD;
               lane_ctl[g].load_x = run_h_ff[g];
            end
            UL_LOAD_B: begin
               lane_ctl[g].op     = LN_LOAD;
               lane_ctl[g].load_x = pre_rd[g];
               lane_ctl[g].load_m = pwd_ff[g];
            end
            UL_MUL: begin
               lane_ctl[g].op = LN_MUL;
            end
            UL_ADD_V: begin
               lane_ctl[g].op = LN_ADD;
            end
            UL_ADD_HD: begin
               lane_ctl[g].op     = LN_ADD;
               lane_ctl[g].addend = hd_ff[g];
            end
            default: begin
            end
         endcase
      end

      spr_lane u_lane (
         .clock   (clock),
         .ctl     (lane_ctl[g]),
         .modulus (MODULUS[g]),
         .acc     (acc[g])
      );
   end

   // block hash against the leading block, both lanes
   always_comb begin
      mismatch = 1'b0;
      for (int i = 0; i < LANES; i++) begin
         mismatch = mismatch || (acc[i] != pre_rd[i]);
      end
   end

   // memory ports
   always_comb begin
      ram_wr_en   = (uw.act == UA_SAVE_H);
      ram_wr_addr = ADDR_W'(len_ff + LEN_W'(1));
      pre_rd_en   = (uw.rd != UR_NONE);
      pw_rd_en    = (uw.rd == UR_D);
      case (uw.rd)
         UR_D:    ram_rd_addr = d_ff;
         UR_LO:   ram_rd_addr = lo_ff;
         UR_HI:   ram_rd_addr = ADDR_W'(hi_ext);
         default: ram_rd_addr = d_ff;
      endcase
   end

   spr_ram #(
      .WIDTH (RAM_W),
      .DEPTH (MAX_LEN + 1)
   ) u_prefix_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (pre_wr_data),
      .rd_en   (pre_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (pre_rd_data)
   );

   spr_ram #(
      .WIDTH (RAM_W),
      .DEPTH (MAX_LEN + 1)
   ) u_power_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (pw_wr_data),
      .rd_en   (pw_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (pw_rd_data)
   );

   // jump condition
   always_comb begin
      case (uw.cond)
         UC_NEXT:      jump = 1'b0;
         UC_ALWAYS:    jump = 1'b1;
         UC_NOT_START: jump = !start;
         UC_LEN_FULL:  jump = (len_ext >= MAX_LEN_C);
         UC_LOOP:      jump = (loop_ff != '0);
         UC_NOT_LAST:  jump = !last_ff;
         UC_OVF:       jump = len_over;
         UC_SUM_EQ:    jump = (sum_ff == len_ext);
         UC_SUM_LE:    jump = (sum_ff <= len_ext);
         UC_LO_EQ:     jump = (CMP_W'(lo_ff) == len_ext);
         UC_LO_NE:     jump = (CMP_W'(lo_ff) != len_ext);
         UC_MISMATCH:  jump = mismatch;
         default:      jump = 1'b0;
      endcase
      upc_in = jump ? uw.target : upc_ff + upc_type'(1);
   end

   // step actions
   always_comb begin
      loop_in         = loop_ff;
      len_in          = len_ff;
      run_h_in        = run_h_ff;
      run_p_in        = run_p_ff;
      rsp_strobe_in   = 1'b0;
      value_in        = value_ff;
      last_in         = last_ff;
      d_in            = d_ff;
      lo_in           = lo_ff;
      sum_in          = sum_ff;
      hd_in           = hd_ff;
      pwd_in          = pwd_ff;
      rsp_period_in   = rsp_period_ff;
      rsp_overflow_in = rsp_overflow_ff;

      // take in a letter beat
      if (accept) begin
         value_in = req_letter - LETTER_OFFSET;
         last_in  = req_last;
      end

      // load the bit counter for a serial multiply, count it down per step
      case (uw.lane)
         UL_LOAD_P, UL_LOAD_H: loop_in = LOOP_W'(BASE_W - 1);
         UL_LOAD_B:            loop_in = LOOP_W'(HASH_W - 1);
         UL_MUL:               loop_in = loop_ff - LOOP_W'(1);
         default:              loop_in = loop_ff;
      endcase

      case (uw.act)
         UA_NONE: begin
         end
         UA_SAVE_P: begin
            run_p_in = acc;
         end
         UA_SAVE_H: begin
            run_h_in = acc;
            len_in   = len_ff + LEN_W'(1);
         end
         UA_MARK_OVF: begin
            len_in = LEN_OVF;
         end
         UA_D_ONE: begin
            d_in = ADDR_W'(1);
         end
         UA_SUM_D: begin
            sum_in = CMP_W'(d_ff);
         end
         UA_SUM_ADD: begin
            sum_in = sum_ff + CMP_W'(d_ff);
         end
         UA_D_INC: begin
            d_in = d_ff + ADDR_W'(1);
         end
         UA_LO_D: begin
            lo_in = d_ff;
         end
         UA_CAP_D: begin
            hd_in  = pre_rd;
            pwd_in = pw_rd;
         end
         UA_LO_ADD: begin
            lo_in = ADDR_W'(hi_ext);
         end
         UA_EMIT: begin
            rsp_strobe_in   = 1'b1;
            rsp_overflow_in = len_over;
            rsp_period_in   = len_over ? '0 : PERIOD_W'(d_ff);
            len_in          = '0;
            for (int i = 0; i < LANES; i++) begin
               run_h_in[i] = '0;
               run_p_in[i] = hash_type'(1);
            end
         end
         default: begin
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff        <= US_IDLE;
         loop_ff       <= '0;
         len_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
         for (int i = 0; i < LANES; i++) begin
            run_h_ff[i] <= '0;
            run_p_ff[i] <= hash_type'(1);
         end
      end else begin
         upc_ff        <= upc_in;
         loop_ff       <= loop_in;
         len_ff        <= len_in;
         rsp_strobe_ff <= rsp_strobe_in;
         run_h_ff      <= run_h_in;
         run_p_ff      <= run_p_in;
      end
   end

   // datapath state
   always_ff @(posedge clock) begin
      value_ff        <= value_in;
      last_ff         <= last_in;
      d_ff            <= d_in;
      lo_ff           <= lo_in;
      sum_ff          <= sum_in;
      hd_ff           <= hd_in;
      pwd_ff          <= pwd_in;
      rsp_period_ff   <= rsp_period_in;
      rsp_overflow_ff <= rsp_overflow_in;
   end

   assign rsp_strobe   = rsp_strobe_ff;
   assign rsp_period   = rsp_period_ff;
   assign rsp_overflow = rsp_overflow_ff;

   // checks
   `SPR_ASSERT_NEXT(a_accept_busy, clock, reset, accept, busy, "busy not raised after a beat")
   `SPR_ASSERT_SAME(a_strobe_emit, clock, reset, rsp_strobe_ff, $past(upc_ff) == US_EMIT,
      "result strobe without an emit step")
   `SPR_ASSERT_SAME(a_strobe_len, clock, reset, rsp_strobe_ff, len_ff == '0,
      "length not cleared with the result")
   `SPR_ASSERT_SAME(a_block_in_range, clock, reset, upc_ff == US_CMP, hi_ext <= len_ext,
      "compared block runs past the string end")

endmodule

>>> design/spr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on spr_pkg for its default width and depth.
module spr_ram #(
   parameter int WIDTH = spr_pkg::HASH_W * spr_pkg::LANES,
   parameter int DEPTH = spr_pkg::MAX_LEN_DEFAULT + 1
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port, and read port that holds its last word when idle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/spr_lane.sv
// One modular arithmetic lane: bit-serial multiply and modular add.
// Depends on spr_pkg for the lane control struct and hash type.
module spr_lane (
   input  logic                  clock,
   input  spr_pkg::lane_ctl_type ctl,
   input  spr_pkg::hash_type     modulus,
   output spr_pkg::hash_type     acc
);
   import spr_pkg::*;

   hash_type acc_ff, acc_in;
   hash_type x_ff, x_in;
   hash_type m_ff, m_in;

   logic [HASH_W+1:0] sum;
   logic [HASH_W+1:0] mod1;
   logic [HASH_W+1:0] mod2;
   logic [HASH_W+1:0] red;
   hash_type          operand;

   // double-and-add step (multiply) or plain add, then bring back below the modulus
   always_comb begin
      mod1 = {2'b00, modulus};
      mod2 = {1'b0, modulus, 1'b0};
      if (ctl.op == LN_MUL) begin
         operand = m_ff[HASH_W-1] ? x_ff : '0;
         sum     = {1'b0, acc_ff, 1'b0} + {2'b00, operand};
      end else begin
         operand = ctl.addend;
         sum     = {2'b00, acc_ff} + {2'b00, operand};
      end
      if (sum >= mod2) begin
         red = sum - mod2;
      end else if (sum >= mod1) begin
         red = sum - mod1;
      end else begin
         red = sum;
      end
   end

   // next state per lane operation
   always_comb begin
      acc_in = acc_ff;
      x_in   = x_ff;
      m_in   = m_ff;
      case (ctl.op)
         LN_HOLD: begin
         end
         LN_LOAD: begin
            acc_in = '0;
            x_in   = ctl.load_x;
            m_in   = ctl.load_m;
         end
         LN_MUL: begin
            acc_in = red[HASH_W-1:0];
            m_in   = {m_ff[HASH_W-2:0], 1'b0};
         end
         LN_ADD: begin
            acc_in = red[HASH_W-1:0];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      x_ff   <= x_in;
      m_ff   <= m_in;
   end

   assign acc = acc_ff;

endmodule
